/* design/assert_macros.svh */
// Assertion shorthand for the cache design.
// Relies on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

/* design/slc_pkg.sv */
// Shared types and constants for the set-associative LRU key cache.
// No dependencies; used by the channel interfaces and the top level.
package slc_pkg;

    // Geometry. SETS must be a power of two: the set is taken from the low quotient bits.
    localparam int SETS       = 64;
    localparam int WAYS       = 8;
    localparam int DATA_WIDTH = 64;

    localparam int KEY_W  = 31;
    localparam int WORD_W = 64;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;

    // key / 100 is computed as ((key >> 2) * RECIP) >> Q_SHIFT, exact for all 31-bit keys.
    localparam int                 QIN_W   = KEY_W - 2;
    localparam int                 RECIP_W = 30;
    localparam int                 PROD_W  = QIN_W + RECIP_W;
    localparam int                 Q_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP   = 30'd687194768;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        OUT_UPDATED = 3'd0,
        OUT_ADDED   = 3'd1,
        OUT_EVICTED = 3'd2,
        OUT_HIT     = 3'd3,
        OUT_MISS    = 3'd4
    } outcome_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_LOOKUP = 1'b1
    } state_t;

    // One way of a set; rank 0 is the most recently written.
    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [DATA_WIDTH-1:0] payload;
        logic [RANK_W-1:0]     rank;
    } way_t;

    // One memory row holds a whole set.
    typedef way_t [WAYS-1:0] row_t;

endpackage

/* design/slc_req_if.sv */
// Request channel of the key cache: opcode, key and payload word.
// Depends on slc_pkg for the field widths.
interface slc_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [slc_pkg::KEY_W-1:0]    key;
    logic [slc_pkg::WORD_W-1:0]   payload_in;

    modport source (output valid, output opcode, output key, output payload_in, input ready);
    modport sink   (input valid, input opcode, input key, input payload_in, output ready);
endinterface

/* design/slc_rsp_if.sv */
// Response channel of the key cache: success flag, payload word and outcome code.
// Depends on slc_pkg for the field widths.
interface slc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         success;
    logic [slc_pkg::WORD_W-1:0]   payload_out;
    logic [2:0]                   outcome;

    modport source (output valid, output success, output payload_out, output outcome, input ready);
    modport sink   (input valid, input success, input payload_out, input outcome, output ready);
endinterface

/* design/set_assoc_lru_key_cache.sv */
// Top level of the set-associative LRU key cache: set memory, lookup and write-back.
// Depends on slc_pkg, slc_req_if, slc_rsp_if and assert_macros.svh.
//
//  Channel | Dir | Word contents
//  --------+-----+---------------------------------------
//  req     | in  | opcode, key, payload_in
//  rsp     | out | success, payload_out, outcome
//
// The set row is read from the single-port set memory when the word is accepted; it is
// compared, updated and written back in the lookup state, which a stalled response holds.
// A new word is not accepted before the read-compare-write of the last one is done.
// Reset clears the per-set valid flags at once; there is no clearing pass.
// A stalled response holds the lookup cycle; the next request is accepted while the
// previous response still waits on rsp.
`include "assert_macros.svh"

module set_assoc_lru_key_cache (
    input logic         clk,
    input logic         rst_n,
    slc_req_if.sink     req,
    slc_rsp_if.source   rsp
);

    slc_pkg::state_t                    state_reg;
    slc_pkg::state_t                    state_next;
    logic                               in_ready;
    logic                               accept;
    logic                               slot_free;
    logic                               finish;
    logic                               wr_en;

    logic [slc_pkg::PROD_W-1:0]         quot_prod;
    logic [slc_pkg::SET_W-1:0]          set_in;

    slc_pkg::op_t                       op_reg;
    logic [slc_pkg::KEY_W-1:0]          key_reg;
    logic [slc_pkg::DATA_WIDTH-1:0]     pay_reg;
    logic [slc_pkg::SET_W-1:0]          set_reg;

    slc_pkg::row_t                      mem [slc_pkg::SETS];
    slc_pkg::row_t                      rd_row_reg;
    logic                               rowv_rd_reg;
    logic [slc_pkg::SETS-1:0]           row_valid_reg;

    logic [slc_pkg::WAYS-1:0]           way_v;
    logic [slc_pkg::WAYS-1:0]           match_vec;
    logic [slc_pkg::WAYS-1:0]           oldest_vec;
    logic                               hit;
    logic                               is_add;
    logic [slc_pkg::WAY_W-1:0]          hit_way;
    logic [slc_pkg::WAY_W-1:0]          free_way;
    logic [slc_pkg::WAY_W-1:0]          old_way;
    logic [slc_pkg::WAY_W-1:0]          tgt_way;
    logic [slc_pkg::RANK_W-1:0]         limit_rank;
    slc_pkg::row_t                      new_row;

    logic                               success_next;
    logic [slc_pkg::WORD_W-1:0]         payload_out_next;
    slc_pkg::outcome_t                  outcome_next;

    logic                               out_valid_reg;
    logic                               success_reg;
    logic [slc_pkg::WORD_W-1:0]         payload_out_reg;
    slc_pkg::outcome_t                  outcome_reg;

    // Lowest-numbered way whose bit is set.
    function automatic logic [slc_pkg::WAY_W-1:0] first_way(input logic [slc_pkg::WAYS-1:0] vec);
        logic [slc_pkg::WAY_W-1:0] idx;
        idx = '0;
        for (int w = slc_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (vec[w])
            begin
                idx = slc_pkg::WAY_W'(w);
            end
        end
        return idx;
    endfunction

    // Handshake terms.
    assign accept    = req.valid && in_ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == slc_pkg::S_LOOKUP) && slot_free;
    assign wr_en     = finish && (op_reg == slc_pkg::OP_PUT);
    assign req.ready = in_ready;

    // Set index: (key / 100) mod SETS by reciprocal multiplication.
    assign quot_prod = slc_pkg::PROD_W'(req.key[slc_pkg::KEY_W-1:2])
                     * slc_pkg::PROD_W'(slc_pkg::RECIP);
    assign set_in    = quot_prod[slc_pkg::Q_SHIFT +: slc_pkg::SET_W];

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and request ready.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            slc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = slc_pkg::S_LOOKUP;
                end
            end
            slc_pkg::S_LOOKUP:
            begin
                if (slot_free)
                begin
                    state_next = slc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slc_pkg::S_IDLE;
            end
        endcase
    end

    // Request word capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= slc_pkg::op_t'(req.opcode);
            key_reg <= req.key;
            pay_reg <= req.payload_in[slc_pkg::DATA_WIDTH-1:0];
            set_reg <= set_in;
        end
    end

    // Set memory: read on accept, write back at the end of a put. The two never coincide.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[set_reg] <= new_row;
        end
        if (accept)
        begin
            rd_row_reg  <= mem[set_in];
            rowv_rd_reg <= row_valid_reg[set_in];
        end
    end

    // Per-set valid flags; a set never written reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[set_reg] <= 1'b1;
        end
    end

    // Per-way compare against the fetched row.
    always_comb
    begin
        for (int w = 0; w < slc_pkg::WAYS; w++)
        begin
            way_v[w]      = rowv_rd_reg && rd_row_reg[w].valid;
            match_vec[w]  = way_v[w] && (rd_row_reg[w].key == key_reg);
            oldest_vec[w] = way_v[w]
                         && (rd_row_reg[w].rank == slc_pkg::RANK_W'(slc_pkg::WAYS - 1));
        end
    end

    assign hit      = |match_vec;
    assign is_add   = !hit && !(&way_v);
    assign hit_way  = first_way(match_vec);
    assign free_way = first_way(~way_v);
    assign old_way  = first_way(oldest_vec);

    // Way that a put writes, and the rank below which the others age on a hit or an eviction.
    always_comb
    begin
        priority if (hit)
        begin
            tgt_way = hit_way;
        end
        else if (is_add)
        begin
            tgt_way = free_way;
        end
        else
        begin
            tgt_way = old_way;
        end
        limit_rank = rd_row_reg[tgt_way].rank;
    end

    // Updated row: the written way becomes most recent, younger valid ways age by one (all on an add).
    always_comb
    begin
        for (int w = 0; w < slc_pkg::WAYS; w++)
        begin
            new_row[w]       = rd_row_reg[w];
            new_row[w].valid = way_v[w];
            if (way_v[w] && (is_add || (rd_row_reg[w].rank < limit_rank)))
            begin
                new_row[w].rank = rd_row_reg[w].rank + slc_pkg::RANK_W'(1);
            end
            if (tgt_way == slc_pkg::WAY_W'(w))
            begin
                new_row[w].valid   = 1'b1;
                new_row[w].key     = key_reg;
                new_row[w].payload = pay_reg;
                new_row[w].rank    = '0;
            end
        end
    end

    // Response word.
    always_comb
    begin
        success_next     = 1'b1;
        payload_out_next = '0;
        if (op_reg == slc_pkg::OP_GET)
        begin
            if (hit)
            begin
                payload_out_next = slc_pkg::WORD_W'(rd_row_reg[hit_way].payload);
                outcome_next     = slc_pkg::OUT_HIT;
            end
            else
            begin
                success_next = 1'b0;
                outcome_next = slc_pkg::OUT_MISS;
            end
        end
        else
        begin
            priority if (hit)
            begin
                outcome_next = slc_pkg::OUT_UPDATED;
            end
            else if (is_add)
            begin
                outcome_next = slc_pkg::OUT_ADDED;
            end
            else
            begin
                outcome_next = slc_pkg::OUT_EVICTED;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register contents.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            success_reg     <= success_next;
            payload_out_reg <= payload_out_next;
            outcome_reg     <= outcome_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.success     = success_reg;
    assign rsp.payload_out = payload_out_reg;
    assign rsp.outcome     = outcome_reg;

    // A key is held at most once in a set.
    `SLC_ASSERT_IMP(a_single_match, state_reg == slc_pkg::S_LOOKUP, $onehot0(match_vec))
    // An accepted word always goes to the lookup cycle.
    `SLC_ASSERT_NXT(a_accept_lookup, accept, state_reg == slc_pkg::S_LOOKUP)
    // A finished lookup leaves a response in the output register.
    `SLC_ASSERT_NXT(a_finish_out, finish, out_valid_reg)
    // A written set is marked valid.
    `SLC_ASSERT_NXT(a_write_valid, wr_en, row_valid_reg[$past(set_reg)])

endmodule

/* verif/tb_set_assoc_lru_key_cache.sv */
// Self-checking testbench for the set-associative LRU key cache: a directed opening
// followed by random put/get traffic, with every response checked against a local model.
// Depends on slc_pkg, slc_req_if, slc_rsp_if and the set_assoc_lru_key_cache top level.
module tb_set_assoc_lru_key_cache;
    import slc_pkg::*;

    localparam int KEY_DIV   = 100;
    localparam int RAND_WORDS = 650;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct {
        op_t              opcode;
        logic [KEY_W-1:0] key;
        logic [WORD_W-1:0] payload;
    } req_word_t;

    typedef struct {
        logic              success;
        logic [WORD_W-1:0] payload_out;
        outcome_t          outcome;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    slc_req_if req ();
    slc_rsp_if rsp ();

    set_assoc_lru_key_cache u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #1 clk = ~clk;

    // Local copy of the cache contents.
    bit                cache_valid [SETS][WAYS];
    logic [KEY_W-1:0]  cache_key   [SETS][WAYS];
    logic [WORD_W-1:0] cache_data  [SETS][WAYS];
    int                cache_rank  [SETS][WAYS];

    req_word_t request_queue[$];
    rsp_word_t pending_replies[$];
    req_word_t cur_word;
    int        words_sent;
    int        total_words;
    int        fail_count;
    int        outcome_tally [5];
    logic [KEY_W-1:0] hot_keys[$];

    // Make one way the most recent; valid ways younger than the limit age by one.
    function automatic void make_recent(int set_idx, int way, int limit);
        for (int w = 0; w < WAYS; w++)
            if (w != way && cache_valid[set_idx][w] && cache_rank[set_idx][w] < limit)
                cache_rank[set_idx][w]++;
        cache_rank[set_idx][way] = 0;
    endfunction

    // Apply one request word to the local cache and return the response it must produce.
    function automatic rsp_word_t cache_apply(req_word_t r);
        int                set_idx;
        int                hit_way;
        int                free_way;
        int                old_way;
        int                old_rank;
        bit                hit;
        bit                has_free;
        logic [WORD_W-1:0] stored;
        rsp_word_t         res;
        set_idx  = int'((longint'(r.key) / KEY_DIV) % SETS);
        hit      = 1'b0;
        has_free = 1'b0;
        hit_way  = 0;
        free_way = 0;
        old_way  = 0;
        old_rank = 0;
        stored   = '0;
        stored[DATA_WIDTH-1:0] = r.payload[DATA_WIDTH-1:0];
        for (int w = 0; w < WAYS; w++)
        begin
            if (cache_valid[set_idx][w])
            begin
                if (!hit && cache_key[set_idx][w] == r.key)
                begin
                    hit     = 1'b1;
                    hit_way = w;
                end
                if (cache_rank[set_idx][w] >= old_rank)
                begin
                    old_rank = cache_rank[set_idx][w];
                    old_way  = w;
                end
            end
            else if (!has_free)
            begin
                has_free = 1'b1;
                free_way = w;
            end
        end
        res.success     = 1'b1;
        res.payload_out = '0;
        if (r.opcode == OP_GET)
        begin
            if (hit)
            begin
                res.payload_out = cache_data[set_idx][hit_way];
                res.outcome     = OUT_HIT;
            end
            else
            begin
                res.success = 1'b0;
                res.outcome = OUT_MISS;
            end
        end
        else if (hit)
        begin
            cache_data[set_idx][hit_way] = stored;
            make_recent(set_idx, hit_way, cache_rank[set_idx][hit_way]);
            res.outcome = OUT_UPDATED;
        end
        else if (has_free)
        begin
            cache_valid[set_idx][free_way] = 1'b1;
            cache_key[set_idx][free_way]   = r.key;
            cache_data[set_idx][free_way]  = stored;
            make_recent(set_idx, free_way, WAYS + 1);
            res.outcome = OUT_ADDED;
        end
        else
        begin
            cache_key[set_idx][old_way]  = r.key;
            cache_data[set_idx][old_way] = stored;
            make_recent(set_idx, old_way, cache_rank[set_idx][old_way]);
            res.outcome = OUT_EVICTED;
        end
        return res;
    endfunction

    function automatic void push_word(op_t op, logic [KEY_W-1:0] key, logic [WORD_W-1:0] pay);
        req_word_t r;
        r.opcode  = op;
        r.key     = key;
        r.payload = pay;
        request_queue.push_back(r);
    endfunction

    // A key that lands in the given set, with random upper quotient and offset.
    function automatic logic [KEY_W-1:0] key_in_set(int set_idx);
        longint q;
        q = longint'($urandom_range(335543)) * SETS + set_idx;
        return KEY_W'(q * KEY_DIV + $urandom_range(KEY_DIV - 1));
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Idle rates per phase: sender-light first, then receiver-light, then none.
    function automatic int src_idle_pct();
        if (words_sent < total_words / 3)
            return 27;
        else if (words_sent < (2 * total_words) / 3)
            return 84;
        return 0;
    endfunction

    function automatic int sink_idle_pct();
        if (words_sent < total_words / 3)
            return 84;
        else if (words_sent < (2 * total_words) / 3)
            return 27;
        return 0;
    endfunction

    // Driver: presents the next request word and records the expected response on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid      <= 1'b0;
            req.opcode     <= OP_PUT;
            req.key        <= '0;
            req.payload_in <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                pending_replies.push_back(cache_apply(cur_word));
                words_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= src_idle_pct())
                begin
                    cur_word = request_queue.pop_front();
                    req.valid      <= 1'b1;
                    req.opcode     <= cur_word.opcode;
                    req.key        <= cur_word.key;
                    req.payload_in <= cur_word.payload;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls the response channel at random and checks each accepted word.
    always @(posedge clk)
    begin
        rsp_word_t exp_rsp;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("unexpected response word: outcome %0d", rsp.outcome);
                    fail_count++;
                end
                else
                begin
                    exp_rsp = pending_replies.pop_front();
                    if (rsp.outcome <= OUT_MISS)
                        outcome_tally[rsp.outcome]++;
                    if (rsp.success !== exp_rsp.success)
                    begin
                        $error("success: expected %0b, actual %0b", exp_rsp.success, rsp.success);
                        fail_count++;
                    end
                    if (rsp.payload_out !== exp_rsp.payload_out)
                    begin
                        $error("payload_out: expected %h, actual %h",
                               exp_rsp.payload_out, rsp.payload_out);
                        fail_count++;
                    end
                    if (rsp.outcome !== exp_rsp.outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d", exp_rsp.outcome, rsp.outcome);
                        fail_count++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= sink_idle_pct());
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int s;
        int set_pick[4];

        // Directed opening: empty-cache miss, key extremes, update, filling one set,
        // eviction of the oldest way and a recency change before a second eviction.
        push_word(OP_GET, '0, rand_word());
        push_word(OP_PUT, '0, '0);
        push_word(OP_GET, '0, '1);
        push_word(OP_PUT, KEY_MAX, '1);
        push_word(OP_GET, KEY_MAX, rand_word());
        push_word(OP_PUT, '0, 64'hA5A5_5A5A_0F0F_F0F0);
        for (int i = 1; i < WAYS; i++)
            push_word(OP_PUT, KEY_W'(i * SETS * KEY_DIV), rand_word());
        push_word(OP_PUT, KEY_W'(KEY_DIV - 1), rand_word());
        push_word(OP_GET, '0, rand_word());
        push_word(OP_PUT, KEY_W'(SETS * KEY_DIV), rand_word());
        push_word(OP_PUT, KEY_W'(WAYS * SETS * KEY_DIV), rand_word());
        push_word(OP_GET, KEY_W'(2 * SETS * KEY_DIV), rand_word());
        push_word(OP_GET, KEY_W'(SETS * KEY_DIV), rand_word());
        push_word(OP_GET, KEY_W'(KEY_DIV), rand_word());
        push_word(OP_GET, KEY_W'(KEY_DIV - 1), '0);

        // Random part: a pool of keys crowded into a few sets so that hits, updates
        // and evictions are common, plus fully random keys as noise.
        set_pick[0] = 0;
        set_pick[1] = SETS - 1;
        set_pick[2] = $urandom_range(SETS - 1);
        set_pick[3] = $urandom_range(SETS - 1);
        for (int i = 0; i < 48; i++)
            hot_keys.push_back(key_in_set(set_pick[i % 4]));
        for (int i = 0; i < RAND_WORDS; i++)
        begin
            s = $urandom_range(99);
            if (s < 85)
                push_word(op_t'($urandom_range(1)), hot_keys[$urandom_range(47)], rand_word());
            else
                push_word(op_t'($urandom_range(1)), KEY_W'($urandom), rand_word());
        end
        total_words = request_queue.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || req.valid)
            @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("tb: %0d request words; %0d hits, %0d misses,", words_sent,
                 outcome_tally[OUT_HIT], outcome_tally[OUT_MISS]);
        $display("tb: %0d added, %0d updated, %0d evicted", outcome_tally[OUT_ADDED],
                 outcome_tally[OUT_UPDATED], outcome_tally[OUT_EVICTED]);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
